[hw/rtl/htb_pkg.sv]
`default_nettype none

package htb_pkg;

	// comment tracking modes
	typedef enum logic [2:0] {
		MODE_NORMAL = 3'd0,
		MODE_SLASH  = 3'd1,
		MODE_LINE   = 3'd2,
		MODE_BLOCK  = 3'd3,
		MODE_STAR   = 3'd4
	} mode_t;

	// result status codes
	localparam logic [1:0] ST_BYTE    = 2'd0;
	localparam logic [1:0] ST_STOP    = 2'd1;
	localparam logic [1:0] ST_MISSING = 2'd2;

	// ascii codes the parser looks for
	localparam logic [7:0] CH_SLASH      = 8'h2F;
	localparam logic [7:0] CH_STAR       = 8'h2A;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_LF         = 8'h0A;
	localparam logic [7:0] CH_CR         = 8'h0D;
	localparam logic [7:0] CH_TAB        = 8'h09;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_DIGIT0     = 8'h30;
	localparam logic [7:0] CH_DIGIT9     = 8'h39;
	localparam logic [7:0] CH_LOWER_A    = 8'h61;
	localparam logic [7:0] CH_LOWER_F    = 8'h66;
	localparam logic [7:0] CH_UPPER_A    = 8'h41;
	localparam logic [7:0] CH_UPPER_F    = 8'h46;

	// input beat payload
	typedef struct packed {
		logic [7:0] text_char;
		logic       end_of_text;
	} in_beat_t;

	// output beat payload
	typedef struct packed {
		logic [7:0] data_byte;
		logic [1:0] status;
	} out_beat_t;

endpackage

`default_nettype wire

[hw/rtl/htb_stream_if.sv]
`default_nettype none

// character channel
interface htb_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_char;
	logic       end_of_text;

	modport source (output valid, output text_char, output end_of_text, input ready);
	modport sink (input valid, input text_char, input end_of_text, output ready);
endinterface

// decoded byte channel
interface htb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic [1:0] status;

	modport source (output valid, output data_byte, output status, input ready);
	modport sink (input valid, input data_byte, input status, output ready);
endinterface

`default_nettype wire

[hw/rtl/hex_text_to_byte_decoder_top.sv]
// A character beat is held in the input register and its result beat in the
// result register; the parser updates in the single decode stage between them.
// Throughput: one character per cycle while the byte output is not stalled.
// Reset (arst_n low, asynchronous): parser idle, no comment, not halted,
// allow_underscore cleared, both pipeline registers empty.
`default_nettype none

module hex_text_to_byte_decoder_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cfg_we,
	input  wire logic  cfg_wdata,
	htb_in_if.sink     text_in,
	htb_out_if.source  byte_out
);

	logic                valid_s1;
	htb_pkg::in_beat_t   beat_s1;
	logic                allow_underscore_q;
	logic                have_high_q;
	logic [3:0]          high_nibble_q;
	htb_pkg::mode_t      mode_q;
	logic                halted_q;
	logic                out_valid_q;
	htb_pkg::out_beat_t  out_beat_q;

	logic                out_free;
	logic                advance;
	logic                is_space;
	logic                is_digit;
	logic                is_lower;
	logic                is_upper;
	logic                is_nibble;
	logic [3:0]          nibble;
	logic                have_high_d;
	logic [3:0]          high_nibble_d;
	htb_pkg::mode_t      mode_d;
	logic                halted_d;
	logic                res_valid;
	htb_pkg::out_beat_t  res_beat;
	logic                fail;

	// handshake: decode stage moves when the result register can take a beat
	assign out_free      = !out_valid_q || byte_out.ready;
	assign advance       = valid_s1 && out_free;
	assign text_in.ready = !valid_s1 || advance;

	assign byte_out.valid     = out_valid_q;
	assign byte_out.data_byte = out_beat_q.data_byte;
	assign byte_out.status    = out_beat_q.status;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_underscore_q <= 1'b0;
		end else if (cfg_we) begin
			allow_underscore_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_in.ready) begin
			valid_s1 <= text_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_in.ready && text_in.valid) begin
			beat_s1.text_char   <= text_in.text_char;
			beat_s1.end_of_text <= text_in.end_of_text;
		end
	end

	// character classes
	always_comb begin
		is_space = (beat_s1.text_char == htb_pkg::CH_SPACE)
			|| (beat_s1.text_char >= htb_pkg::CH_TAB && beat_s1.text_char <= htb_pkg::CH_CR);
		is_digit = beat_s1.text_char >= htb_pkg::CH_DIGIT0
			&& beat_s1.text_char <= htb_pkg::CH_DIGIT9;
		is_lower = beat_s1.text_char >= htb_pkg::CH_LOWER_A
			&& beat_s1.text_char <= htb_pkg::CH_LOWER_F;
		is_upper = beat_s1.text_char >= htb_pkg::CH_UPPER_A
			&& beat_s1.text_char <= htb_pkg::CH_UPPER_F;
		is_nibble = is_digit || is_lower || is_upper
			|| (allow_underscore_q && beat_s1.text_char == htb_pkg::CH_UNDERSCORE);
		// letters of either case: low bits 1..6 map to 10..15
		if (is_digit) begin
			nibble = beat_s1.text_char[3:0];
		end else if (is_lower || is_upper) begin
			nibble = beat_s1.text_char[3:0] + 4'd9;
		end else begin
			nibble = 4'd0;
		end
	end

	// parser next state and result
	always_comb begin
		have_high_d   = have_high_q;
		high_nibble_d = high_nibble_q;
		mode_d        = mode_q;
		halted_d      = halted_q;
		res_valid     = 1'b0;
		res_beat      = '{data_byte: 8'd0, status: htb_pkg::ST_BYTE};
		fail          = 1'b0;

		if (beat_s1.end_of_text) begin
			// end marker: report an open pair or a pending slash, then restart
			if (!halted_q && (have_high_q || mode_q == htb_pkg::MODE_SLASH)) begin
				res_valid       = 1'b1;
				res_beat.status = have_high_q ? htb_pkg::ST_MISSING : htb_pkg::ST_STOP;
			end
			have_high_d   = 1'b0;
			high_nibble_d = 4'd0;
			mode_d        = htb_pkg::MODE_NORMAL;
			halted_d      = 1'b0;
		end else if (!halted_q) begin
			case (mode_q)
				htb_pkg::MODE_SLASH: begin
					if (beat_s1.text_char == htb_pkg::CH_SLASH) begin
						mode_d = htb_pkg::MODE_LINE;
					end else if (beat_s1.text_char == htb_pkg::CH_STAR) begin
						mode_d = htb_pkg::MODE_BLOCK;
					end else begin
						fail = 1'b1;
					end
				end
				htb_pkg::MODE_LINE: begin
					if (beat_s1.text_char == htb_pkg::CH_LF
						|| beat_s1.text_char == htb_pkg::CH_CR) begin
						mode_d = htb_pkg::MODE_NORMAL;
					end
				end
				htb_pkg::MODE_BLOCK: begin
					if (beat_s1.text_char == htb_pkg::CH_STAR) begin
						mode_d = htb_pkg::MODE_STAR;
					end
				end
				htb_pkg::MODE_STAR: begin
					if (beat_s1.text_char == htb_pkg::CH_SLASH) begin
						mode_d = htb_pkg::MODE_NORMAL;
					end else if (beat_s1.text_char != htb_pkg::CH_STAR) begin
						mode_d = htb_pkg::MODE_BLOCK;
					end
				end
				default: begin
					// normal text
					mode_d = htb_pkg::MODE_NORMAL;
					if (is_space) begin
						mode_d = htb_pkg::MODE_NORMAL;
					end else if (beat_s1.text_char == htb_pkg::CH_SLASH) begin
						mode_d = htb_pkg::MODE_SLASH;
					end else if (!is_nibble) begin
						fail = 1'b1;
					end else if (!have_high_q) begin
						have_high_d   = 1'b1;
						high_nibble_d = nibble;
					end else begin
						res_valid          = 1'b1;
						res_beat.data_byte = {high_nibble_q, nibble};
						have_high_d        = 1'b0;
						high_nibble_d      = 4'd0;
					end
				end
			endcase

			// non-hex char or slash not opening a comment: stop or missing nibble, then halt
			if (fail) begin
				res_valid       = 1'b1;
				res_beat.status = have_high_q ? htb_pkg::ST_MISSING : htb_pkg::ST_STOP;
				have_high_d     = 1'b0;
				high_nibble_d   = 4'd0;
				mode_d          = htb_pkg::MODE_NORMAL;
				halted_d        = 1'b1;
			end
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_high_q   <= 1'b0;
			high_nibble_q <= 4'd0;
			mode_q        <= htb_pkg::MODE_NORMAL;
			halted_q      <= 1'b0;
		end else if (advance) begin
			have_high_q   <= have_high_d;
			high_nibble_q <= high_nibble_d;
			mode_q        <= mode_d;
			halted_q      <= halted_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_beat_q <= res_beat;
		end
	end

endmodule

`default_nettype wire

[sim/tb_hex_text_to_byte_decoder_top.sv]
module tb_hex_text_to_byte_decoder_top;

	localparam int RUN_LIMIT = 100000;
	localparam int STALL_LEN = 300;
	localparam int DRAIN_WAIT = 8;
	localparam int PHASE_CHARS = 380;
	localparam int PRINT_CAP = 40;
	localparam logic [7:0] CH_VT = 8'h0B;
	localparam logic [7:0] CH_FF = 8'h0C;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	htb_in_if  text_ch ();
	htb_out_if byte_ch ();

	hex_text_to_byte_decoder_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.text_in   (text_ch),
		.byte_out  (byte_ch)
	);

	// characters waiting to be offered, and decoded beats still owed by the block
	htb_pkg::in_beat_t  char_queue[$];
	htb_pkg::out_beat_t expected_bytes[$];
	htb_pkg::in_beat_t  next_char;
	int        queued_chars = 0;
	int        errors = 0;
	bit        calm = 1'b0;
	int        stall_asks = 0;
	int        stall_done = 0;
	int        stall_left = 0;

	// parser shadow state
	logic            pr_underscore;
	logic            pr_have_hi;
	logic [3:0]      pr_hi;
	htb_pkg::mode_t  pr_mode;
	logic            pr_halted;

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// watchdog
	initial begin
		repeat (RUN_LIMIT) @(posedge clk);
		$display("== FAIL ==");
		$finish;
	end

	task automatic report_mismatch(input string what);
		if (errors < PRINT_CAP)
			$display("mismatch at %0t: %s", $time, what);
		errors++;
	endtask

	function automatic int hex_value(input logic [7:0] c);
		if (c >= htb_pkg::CH_DIGIT0 && c <= htb_pkg::CH_DIGIT9)
			return int'(c - htb_pkg::CH_DIGIT0);
		if (c >= htb_pkg::CH_LOWER_A && c <= htb_pkg::CH_LOWER_F)
			return int'(c - htb_pkg::CH_LOWER_A) + 10;
		if (c >= htb_pkg::CH_UPPER_A && c <= htb_pkg::CH_UPPER_F)
			return int'(c - htb_pkg::CH_UPPER_A) + 10;
		if (c == htb_pkg::CH_UNDERSCORE && pr_underscore)
			return 0;
		return -1;
	endfunction

	function automatic bit is_blank(input logic [7:0] c);
		return c == htb_pkg::CH_SPACE || c == htb_pkg::CH_TAB || c == htb_pkg::CH_LF ||
			c == CH_VT || c == CH_FF || c == htb_pkg::CH_CR;
	endfunction

	task automatic clear_parse();
		pr_have_hi = 1'b0;
		pr_hi = 4'h0;
		pr_mode = htb_pkg::MODE_NORMAL;
		pr_halted = 1'b0;
	endtask

	// non-hex char or slash not opening a comment: stop at first nibble, missing at second
	task automatic halt_parse();
		htb_pkg::out_beat_t r;
		r.data_byte = 8'h00;
		r.status = pr_have_hi ? htb_pkg::ST_MISSING : htb_pkg::ST_STOP;
		expected_bytes.push_back(r);
		pr_have_hi = 1'b0;
		pr_hi = 4'h0;
		pr_mode = htb_pkg::MODE_NORMAL;
		pr_halted = 1'b1;
	endtask

	// advance the shadow parser by one accepted character beat
	task automatic decode_char(input htb_pkg::in_beat_t b);
		htb_pkg::out_beat_t r;
		int                 n;
		logic [7:0]         c;
		c = b.text_char;
		if (b.end_of_text) begin
			if (!pr_halted && (pr_have_hi || pr_mode == htb_pkg::MODE_SLASH)) begin
				r.data_byte = 8'h00;
				r.status = pr_have_hi ? htb_pkg::ST_MISSING : htb_pkg::ST_STOP;
				expected_bytes.push_back(r);
			end
			clear_parse();
			return;
		end
		if (pr_halted)
			return;
		case (pr_mode)
			htb_pkg::MODE_SLASH: begin
				if (c == htb_pkg::CH_SLASH)
					pr_mode = htb_pkg::MODE_LINE;
				else if (c == htb_pkg::CH_STAR)
					pr_mode = htb_pkg::MODE_BLOCK;
				else
					halt_parse();
				return;
			end
			htb_pkg::MODE_LINE: begin
				if (c == htb_pkg::CH_LF || c == htb_pkg::CH_CR)
					pr_mode = htb_pkg::MODE_NORMAL;
				return;
			end
			htb_pkg::MODE_BLOCK: begin
				if (c == htb_pkg::CH_STAR)
					pr_mode = htb_pkg::MODE_STAR;
				return;
			end
			htb_pkg::MODE_STAR: begin
				if (c == htb_pkg::CH_SLASH)
					pr_mode = htb_pkg::MODE_NORMAL;
				else if (c != htb_pkg::CH_STAR)
					pr_mode = htb_pkg::MODE_BLOCK;
				return;
			end
			default: pr_mode = htb_pkg::MODE_NORMAL;
		endcase
		if (is_blank(c))
			return;
		if (c == htb_pkg::CH_SLASH) begin
			pr_mode = htb_pkg::MODE_SLASH;
			return;
		end
		n = hex_value(c);
		if (n < 0) begin
			halt_parse();
			return;
		end
		if (!pr_have_hi) begin
			pr_have_hi = 1'b1;
			pr_hi = n[3:0];
			return;
		end
		r.data_byte = {pr_hi, n[3:0]};
		r.status = htb_pkg::ST_BYTE;
		expected_bytes.push_back(r);
		pr_have_hi = 1'b0;
		pr_hi = 4'h0;
	endtask

	task automatic check_byte(input logic [7:0] got_byte, input logic [1:0] got_status);
		htb_pkg::out_beat_t want;
		if (expected_bytes.size() == 0) begin
			report_mismatch($sformatf("unexpected beat byte %02h status %0d",
				got_byte, got_status));
			return;
		end
		want = expected_bytes.pop_front();
		if (got_status !== want.status)
			report_mismatch($sformatf("status %0d, want %0d", got_status, want.status));
		if (got_byte !== want.data_byte)
			report_mismatch($sformatf("byte %02h, want %02h", got_byte, want.data_byte));
	endtask

	// character driver: predict each accepted beat, then offer the next one
	always @(posedge clk) begin
		if (text_ch.valid && text_ch.ready)
			decode_char(htb_pkg::in_beat_t'{text_ch.text_char, text_ch.end_of_text});
		if (!text_ch.valid || text_ch.ready) begin
			if (char_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 14)) begin
				next_char = char_queue.pop_front();
				text_ch.valid <= 1'b1;
				text_ch.text_char <= next_char.text_char;
				text_ch.end_of_text <= next_char.end_of_text;
			end else begin
				text_ch.valid <= 1'b0;
			end
		end
	end

	// byte monitor: check each beat, random ready, long hold-off on request
	always @(posedge clk) begin
		if (byte_ch.valid && byte_ch.ready)
			check_byte(byte_ch.data_byte, byte_ch.status);
		if (stall_left != 0) begin
			stall_left = stall_left - 1;
			byte_ch.ready <= 1'b0;
		end else if (stall_done != stall_asks) begin
			stall_done = stall_done + 1;
			stall_left = STALL_LEN;
			byte_ch.ready <= 1'b0;
		end else begin
			byte_ch.ready <= calm || ($urandom_range(0, 99) >= 14);
		end
	end

	task automatic put_char(input logic [7:0] c);
		char_queue.push_back(htb_pkg::in_beat_t'{c, 1'b0});
		queued_chars++;
	endtask

	task automatic put_end();
		char_queue.push_back(htb_pkg::in_beat_t'{8'($urandom_range(0, 255)), 1'b1});
		queued_chars++;
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_char(s[i]);
	endtask

	function automatic logic [7:0] digit_char(input int v, input bit under_ok);
		if (v == 0 && under_ok && $urandom_range(0, 3) == 0)
			return htb_pkg::CH_UNDERSCORE;
		if (v < 10)
			return htb_pkg::CH_DIGIT0 + 8'(v);
		if ($urandom_range(0, 1) != 0)
			return htb_pkg::CH_UPPER_A + 8'(v - 10);
		return htb_pkg::CH_LOWER_A + 8'(v - 10);
	endfunction

	// optional whitespace or a complete comment with random content
	task automatic put_filler();
		logic [7:0] c;
		int         len;
		case ($urandom_range(0, 11))
			0: put_char(htb_pkg::CH_SPACE);
			1: put_char(htb_pkg::CH_TAB);
			2: put_char(htb_pkg::CH_LF);
			3: put_char(CH_VT);
			4: put_char(CH_FF);
			5: put_char(htb_pkg::CH_CR);
			6: begin
				put_char(htb_pkg::CH_SLASH);
				put_char(htb_pkg::CH_SLASH);
				len = $urandom_range(0, 6);
				for (int i = 0; i < len; i++) begin
					c = 8'($urandom_range(0, 255));
					if (c == htb_pkg::CH_LF || c == htb_pkg::CH_CR)
						c = htb_pkg::CH_UPPER_A;
					put_char(c);
				end
				put_char($urandom_range(0, 1) ? htb_pkg::CH_LF : htb_pkg::CH_CR);
			end
			7: begin
				put_char(htb_pkg::CH_SLASH);
				put_char(htb_pkg::CH_STAR);
				len = $urandom_range(0, 6);
				for (int i = 0; i < len; i++) begin
					c = 8'($urandom_range(0, 255));
					// a star followed by anything but a slash stays in the comment
					if (c == htb_pkg::CH_STAR) begin
						put_char(htb_pkg::CH_STAR);
						c = 8'($urandom_range(0, 255));
						if (c == htb_pkg::CH_STAR || c == htb_pkg::CH_SLASH)
							c = htb_pkg::CH_LOWER_A;
					end
					put_char(c);
				end
				len = $urandom_range(1, 3);
				for (int i = 0; i < len; i++)
					put_char(htb_pkg::CH_STAR);
				put_char(htb_pkg::CH_SLASH);
			end
			default: ;
		endcase
	endtask

	// a break in an otherwise well-formed text
	task automatic put_noise();
		case ($urandom_range(0, 4))
			0: put_char(8'($urandom_range(0, 255)));
			1: put_end();
			2: begin
				put_char(htb_pkg::CH_SLASH);
				put_char(8'($urandom_range(0, 255)));
			end
			3: begin
				put_char(htb_pkg::CH_SLASH);
				put_end();
			end
			default: put_char(htb_pkg::CH_UNDERSCORE);
		endcase
	endtask

	// mostly well-formed hex text, sometimes broken, sometimes pure garbage
	task automatic put_random_text(input bit under_ok);
		int pairs;
		int noise_at;
		int len;
		if ($urandom_range(0, 19) == 0) begin
			len = $urandom_range(1, 8);
			for (int i = 0; i < len; i++)
				put_char(8'($urandom_range(0, 255)));
			put_end();
			return;
		end
		pairs = $urandom_range(1, 12);
		noise_at = ($urandom_range(0, 99) < 85) ? -1 : $urandom_range(0, 2 * pairs);
		for (int i = 0; i < 2 * pairs; i++) begin
			if (i == noise_at)
				put_noise();
			put_filler();
			put_char(digit_char($urandom_range(0, 15), under_ok));
		end
		if (noise_at == 2 * pairs)
			put_noise();
		put_filler();
		put_end();
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (char_queue.size() != 0 || text_ch.valid || expected_bytes.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_underscore(input logic v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		pr_underscore = v;
	endtask

	task automatic run_random_phase(input logic under, input bit with_stall);
		int start;
		write_underscore(under);
		@(negedge clk);
		start = queued_chars;
		while (queued_chars - start < PHASE_CHARS)
			put_random_text(under);
		// hold the receiver off while the sender keeps offering
		if (with_stall)
			stall_asks = stall_asks + 1;
		wait_idle();
	endtask

	// stimulus and phase control
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		text_ch.valid = 1'b0;
		text_ch.text_char = 8'h00;
		text_ch.end_of_text = 1'b0;
		byte_ch.ready = 1'b0;
		pr_underscore = 1'b0;
		clear_parse();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, underscore off: pairs, comments inside a pair, stop and error cases
		@(negedge clk);
		put_text("00 fF");
		put_text("9/***/A");
		put_text("0//\nf");
		put_char(htb_pkg::CH_UNDERSCORE);
		put_char(htb_pkg::CH_DIGIT0 + 8'd7);
		put_end();
		put_char(htb_pkg::CH_DIGIT0 + 8'd5);
		put_end();
		put_char(htb_pkg::CH_SLASH);
		put_end();
		put_char(htb_pkg::CH_SLASH);
		put_char(8'hFF);
		put_end();
		put_char(htb_pkg::CH_DIGIT0 + 8'd1);
		put_char(8'h00);
		put_end();
		put_char(8'hFF);
		put_end();
		wait_idle();

		// directed, underscore on: zero nibble on either side
		write_underscore(1'b1);
		@(negedge clk);
		put_text("_ac_");
		put_end();
		wait_idle();

		run_random_phase(1'b1, 1'b0);
		run_random_phase(1'b0, 1'b1);
		calm = 1'b1;
		run_random_phase(1'b1, 1'b0);
		calm = 1'b0;
		run_random_phase(1'b0, 1'b0);
		run_random_phase(1'b1, 1'b1);

		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
